>>> hdl/safp_pkg.sv
// Shared types and constants for the sprite atlas first-fit placer.
// Command and status structs joining safp_ctrl and safp_dp; no dependencies.
package safp_pkg;

  localparam int DIM_W      = 13;
  localparam int FMT_W      = 4;
  localparam int FLD_W      = 14;
  localparam int PAD_W      = 7;
  localparam int AREA_W     = 27;
  localparam int CRD_W      = 15;
  localparam int TIDX_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_W   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_H   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POW2    = 4'd3;

  localparam logic [DIM_W-1:0] RST_MAX_W   = 13'd2048;
  localparam logic [DIM_W-1:0] RST_MAX_H   = 13'd2048;
  localparam logic [PAD_W-1:0] RST_PADDING = 7'd2;
  localparam logic             RST_POW2    = 1'b1;

  typedef struct packed {
    logic accept;
    logic prep;
    logic tex_first;
    logic tex_next;
    logic scan_start;
    logic row_next;
    logic x_next;
    logic sweep_start;
    logic sweep_step;
    logic use_ref;
    logic ref_start;
    logic ref_next;
    logic new_area;
    logic new_tex;
    logic place;
    logic ovf;
  } cmd_t;

  typedef struct packed {
    logic box_full;
    logic tex_full;
    logic direct;
    logic tex_end;
    logic tex_ok;
    logic row_ok;
    logic col_ok;
    logic sweep_hit;
    logic sweep_done;
    logic ref_in;
  } stat_t;

  function automatic logic [FLD_W-1:0] round_pow2(input logic [FLD_W-1:0] v);
    logic [FLD_W-1:0] r;
    r = 14'h2000;
    for (int i = FLD_W - 2; i >= 0; i--) begin
      if ((14'd1 << i) >= v) r = 14'd1 << i;
    end
    return r;
  endfunction

endpackage

>>> hdl/safp_dp.sv
// Placer datapath: configuration, texture table, box memory, scan counters.
// Driven by safp_ctrl through safp_pkg::cmd_t; depends on safp_pkg.
module safp_dp #(
  parameter int MAX_TEXTURES = 16,
  parameter int MAX_BOXES    = 256,
  parameter int COARSE_STEP  = 8,
  parameter int COORD_BITS   = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [safp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [safp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [safp_pkg::DIM_W-1:0]       sprite_width,
  input  logic [safp_pkg::DIM_W-1:0]       sprite_height,
  input  logic [safp_pkg::FMT_W-1:0]       format_code,
  input  logic                             no_merge,
  input  safp_pkg::cmd_t                   cmd,
  output safp_pkg::stat_t                  stat,
  output logic [safp_pkg::TIDX_W-1:0]      texture_index,
  output logic [COORD_BITS-1:0]            box_x,
  output logic [COORD_BITS-1:0]            box_y,
  output logic                             opened_new,
  output logic                             overflow
);
  import safp_pkg::*;

  localparam int TCW = $clog2(MAX_TEXTURES + 1);
  localparam int TI  = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
  localparam int BCW = $clog2(MAX_BOXES + 1);
  localparam int BI  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int ODW = (COARSE_STEP > 1) ? $clog2(COARSE_STEP) : 1;
  localparam int BOX_W = 4 * FLD_W;

  logic [DIM_W-1:0]  max_w, max_h;
  logic [PAD_W-1:0]  pad;
  logic              pow2;

  logic [DIM_W-1:0]  sw, sh;
  logic [FMT_W-1:0]  fmt;
  logic              nm;
  logic [FLD_W-1:0]  bw, bh, ntw, nth;
  logic [AREA_W-1:0] area, barea, ntarea;

  logic [TCW-1:0]    tex_count, t;
  logic [FMT_W-1:0]  tex_fmt  [MAX_TEXTURES];
  logic              tex_unm  [MAX_TEXTURES];
  logic [FLD_W-1:0]  tex_w    [MAX_TEXTURES];
  logic [FLD_W-1:0]  tex_h    [MAX_TEXTURES];
  logic [AREA_W-1:0] tex_free [MAX_TEXTURES];

  logic [BCW-1:0]    box_count, k;
  logic              rv;
  logic [BOX_W-1:0]  box_mem [MAX_BOXES];
  logic [TI-1:0]     own_mem [MAX_BOXES];
  logic [BOX_W-1:0]  rd_box;
  logic [TI-1:0]     rd_own;

  logic [CRD_W-1:0]  gx, gy;
  logic [ODW-1:0]    dx, dy;

  logic [TIDX_W-1:0] o_idx;
  logic [15:0]       o_x, o_y;
  logic              o_new, o_ovf;

  logic [TI-1:0]     ti, tci;
  logic [BI-1:0]     ki, bi;
  logic              direct;
  logic [FLD_W-1:0]  ntw_pre, nth_pre, cur_tw, cur_th;
  logic [CRD_W-1:0]  cand_x, cand_y;
  logic [25:0]       prod_a;
  logic [27:0]       prod_b, prod_c;
  logic [15:0]       cx, cy, bx, by, bxe, bye, cxe, cye;
  logic              ovl;
  logic [AREA_W-1:0] free_cur, free_place, free_new;
  logic [TCW+TIDX_W-1:0] t_ext, tc_ext;

  assign ti  = t[TI-1:0];
  assign tci = tex_count[TI-1:0];
  assign ki  = k[BI-1:0];
  assign bi  = box_count[BI-1:0];

  assign direct  = nm | (sw > max_w) | (sh > max_h);
  assign ntw_pre = direct ? {1'b0, sw} : {1'b0, max_w};
  assign nth_pre = direct ? {1'b0, sh} : {1'b0, max_h};
  assign prod_a  = sw * sh;
  assign prod_b  = bw * bh;
  assign prod_c  = ntw * nth;

  assign cur_tw   = tex_w[ti];
  assign cur_th   = tex_h[ti];
  assign free_cur = tex_free[ti];

  assign cand_x = cmd.use_ref ? gx - CRD_W'(dx) : gx;
  assign cand_y = cmd.use_ref ? gy - CRD_W'(dy) : gy;

  assign cx  = 16'(cand_x);
  assign cy  = 16'(cand_y);
  assign bx  = 16'(rd_box[FLD_W-1:0]);
  assign by  = 16'(rd_box[2*FLD_W-1:FLD_W]);
  assign bxe = bx + 16'(rd_box[3*FLD_W-1:2*FLD_W]);
  assign bye = by + 16'(rd_box[4*FLD_W-1:3*FLD_W]);
  assign cxe = cx + 16'(bw);
  assign cye = cy + 16'(bh);
  assign ovl = (cx < bxe) && (bx < cxe) && (cy < bye) && (by < cye);

  assign free_place = (free_cur > barea) ? free_cur - barea : '0;
  assign free_new   = (ntarea > barea) ? ntarea - barea : '0;

  assign t_ext  = (TCW + TIDX_W)'(t);
  assign tc_ext = (TCW + TIDX_W)'(tex_count);

  always_comb begin
    stat.box_full   = (box_count == BCW'(MAX_BOXES));
    stat.tex_full   = (tex_count == TCW'(MAX_TEXTURES));
    stat.direct     = direct;
    stat.tex_end    = (t == tex_count);
    stat.tex_ok     = (tex_fmt[ti] == fmt) && !tex_unm[ti] && (free_cur >= area);
    stat.row_ok     = (16'(gy) + 16'(bh)) < 16'(cur_th);
    stat.col_ok     = (16'(gx) + 16'(bw)) < 16'(cur_tw);
    stat.sweep_hit  = rv && (rd_own == ti) && ovl;
    stat.sweep_done = (k == box_count) && !rv;
    stat.ref_in     = (gx >= CRD_W'(dx)) && (gy >= CRD_W'(dy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_w     <= RST_MAX_W;
      max_h     <= RST_MAX_H;
      pad       <= RST_PADDING;
      pow2      <= RST_POW2;
      tex_count <= '0;
      box_count <= '0;
      rv        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_W:   max_w <= cfg_data;
          CFG_MAX_H:   max_h <= cfg_data;
          CFG_PADDING: pad   <= cfg_data[PAD_W-1:0];
          CFG_POW2:    pow2  <= cfg_data[0];
          default:     ;
        endcase
      end
      if (cmd.sweep_start) begin
        rv <= 1'b0;
      end else if (cmd.sweep_step) begin
        rv <= (k < box_count);
      end
      if (cmd.place) box_count <= box_count + 1'b1;
      if (cmd.new_tex) begin
        box_count <= box_count + 1'b1;
        tex_count <= tex_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sw  <= sprite_width;
      sh  <= sprite_height;
      fmt <= format_code;
      nm  <= no_merge;
      bw  <= no_merge ? {1'b0, sprite_width}
                      : {1'b0, sprite_width} + FLD_W'({pad, 1'b0});
      bh  <= no_merge ? {1'b0, sprite_height}
                      : {1'b0, sprite_height} + FLD_W'({pad, 1'b0});
    end
    if (cmd.prep) begin
      area  <= AREA_W'(prod_a);
      barea <= prod_b[AREA_W-1:0];
      ntw   <= pow2 ? round_pow2(ntw_pre) : ntw_pre;
      nth   <= pow2 ? round_pow2(nth_pre) : nth_pre;
    end
    if (cmd.new_area) ntarea <= prod_c[AREA_W-1:0];

    if (cmd.tex_first) t <= '0;
    else if (cmd.tex_next) t <= t + 1'b1;

    if (cmd.scan_start) begin
      gx <= '0;
      gy <= '0;
    end else if (cmd.row_next) begin
      gx <= '0;
      gy <= gy + CRD_W'(COARSE_STEP);
    end else if (cmd.x_next) begin
      gx <= gx + CRD_W'(COARSE_STEP);
    end

    if (cmd.ref_start) begin
      dx <= ODW'(COARSE_STEP - 1);
      dy <= ODW'(COARSE_STEP - 1);
    end else if (cmd.ref_next) begin
      if (dx == '0) begin
        dx <= ODW'(COARSE_STEP - 1);
        dy <= dy - 1'b1;
      end else begin
        dx <= dx - 1'b1;
      end
    end

    if (cmd.sweep_start) k <= '0;
    else if (cmd.sweep_step && (k < box_count)) k <= k + 1'b1;

    if (cmd.place) begin
      tex_free[ti] <= free_place;
      o_idx <= t_ext[TIDX_W-1:0];
      o_x   <= 16'(cand_x);
      o_y   <= 16'(cand_y);
      o_new <= 1'b0;
      o_ovf <= 1'b0;
    end
    if (cmd.new_tex) begin
      tex_fmt[tci]  <= fmt;
      tex_unm[tci]  <= nm;
      tex_w[tci]    <= ntw;
      tex_h[tci]    <= nth;
      tex_free[tci] <= free_new;
      o_idx <= tc_ext[TIDX_W-1:0];
      o_x   <= '0;
      o_y   <= '0;
      o_new <= 1'b1;
      o_ovf <= 1'b0;
    end
    if (cmd.ovf) begin
      o_idx <= '0;
      o_x   <= '0;
      o_y   <= '0;
      o_new <= 1'b0;
      o_ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      box_mem[bi] <= {bh, bw, cand_y[FLD_W-1:0], cand_x[FLD_W-1:0]};
      own_mem[bi] <= ti;
    end else if (cmd.new_tex) begin
      box_mem[bi] <= {bh, bw, {FLD_W{1'b0}}, {FLD_W{1'b0}}};
      own_mem[bi] <= tci;
    end
    rd_box <= box_mem[ki];
    rd_own <= own_mem[ki];
  end

  assign texture_index = o_idx;
  assign box_x         = o_x[COORD_BITS-1:0];
  assign box_y         = o_y[COORD_BITS-1:0];
  assign opened_new    = o_new;
  assign overflow      = o_ovf;

endmodule

>>> hdl/safp_ctrl.sv
// Placer controller: one-hot state machine sequencing the datapath.
// Issues safp_pkg::cmd_t, reads safp_pkg::stat_t; depends on safp_pkg.
module safp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  safp_pkg::stat_t stat,
  output safp_pkg::cmd_t  cmd
);
  import safp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PREP   = 11'b00000000010,
    S_TEXCHK = 11'b00000000100,
    S_GRID   = 11'b00000001000,
    S_CSWEEP = 11'b00000010000,
    S_ROFF   = 11'b00000100000,
    S_RSWEEP = 11'b00001000000,
    S_PLACE  = 11'b00010000000,
    S_NEWA   = 11'b00100000000,
    S_NEWT   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (stat.box_full) begin
          cmd.ovf    = 1'b1;
          state_next = S_OUT;
        end else if (stat.direct) begin
          state_next = S_NEWA;
        end else begin
          cmd.tex_first = 1'b1;
          state_next    = S_TEXCHK;
        end
      end
      S_TEXCHK: begin
        if (stat.tex_end) begin
          state_next = S_NEWA;
        end else if (stat.tex_ok) begin
          cmd.scan_start = 1'b1;
          state_next     = S_GRID;
        end else begin
          cmd.tex_next = 1'b1;
        end
      end
      S_GRID: begin
        if (!stat.row_ok) begin
          cmd.tex_next = 1'b1;
          state_next   = S_TEXCHK;
        end else if (stat.col_ok) begin
          cmd.sweep_start = 1'b1;
          state_next      = S_CSWEEP;
        end else begin
          cmd.row_next = 1'b1;
        end
      end
      S_CSWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_hit) begin
          cmd.x_next = 1'b1;
          state_next = S_GRID;
        end else if (stat.sweep_done) begin
          cmd.ref_start = 1'b1;
          state_next    = S_ROFF;
        end
      end
      S_ROFF: begin
        cmd.use_ref = 1'b1;
        if (stat.ref_in) begin
          cmd.sweep_start = 1'b1;
          state_next      = S_RSWEEP;
        end else begin
          cmd.ref_next = 1'b1;
        end
      end
      S_RSWEEP: begin
        cmd.use_ref    = 1'b1;
        cmd.sweep_step = 1'b1;
        if (stat.sweep_hit) begin
          cmd.ref_next = 1'b1;
          state_next   = S_ROFF;
        end else if (stat.sweep_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.use_ref = 1'b1;
        cmd.place   = 1'b1;
        state_next  = S_OUT;
      end
      S_NEWA: begin
        cmd.new_area = 1'b1;
        state_next   = S_NEWT;
      end
      S_NEWT: begin
        if (stat.tex_full) cmd.ovf = 1'b1;
        else               cmd.new_tex = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/sprite_atlas_first_fit_placer_core.sv
// Top level of the sprite atlas first-fit placer: safp_ctrl plus safp_dp.
// Depends on safp_pkg, safp_ctrl and safp_dp.
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, sprite_*, format_code,     request in
//            no_merge
//   out      out_valid/out_ready, texture_index, box_*,    request out
//            opened_new, overflow
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data      register write in
//
// One request at a time. A new texture or a full texture table passes S_NEWA and
// S_NEWT before S_OUT; a full box table goes from S_PREP straight to S_OUT.
// A merged search steps through S_TEXCHK per texture tried, S_GRID per grid point
// and S_ROFF per refinement offset, a box-table sweep (box memory read one entry
// at a time, cut short at the first overlap) and S_PLACE to place.
// Reset clears counts and restores register defaults; no clearing pass.
// The result register holds until out_ready; cfg writes are always taken.
module sprite_atlas_first_fit_placer_core #(
  parameter int MAX_TEXTURES = 16,
  parameter int MAX_BOXES    = 256,
  parameter int COARSE_STEP  = 8,
  parameter int COORD_BITS   = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [safp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [safp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [safp_pkg::DIM_W-1:0]       sprite_width,
  input  logic [safp_pkg::DIM_W-1:0]       sprite_height,
  input  logic [safp_pkg::FMT_W-1:0]       format_code,
  input  logic                             no_merge,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [safp_pkg::TIDX_W-1:0]      texture_index,
  output logic [COORD_BITS-1:0]            box_x,
  output logic [COORD_BITS-1:0]            box_y,
  output logic                             opened_new,
  output logic                             overflow
);
  import safp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  safp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  safp_dp #(
    .MAX_TEXTURES (MAX_TEXTURES),
    .MAX_BOXES    (MAX_BOXES),
    .COARSE_STEP  (COARSE_STEP),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .format_code   (format_code),
    .no_merge      (no_merge),
    .cmd           (cmd),
    .stat          (stat),
    .texture_index (texture_index),
    .box_x         (box_x),
    .box_y         (box_y),
    .opened_new    (opened_new),
    .overflow      (overflow)
  );

endmodule

>>> test/safp_placement_checker.sv
// Placement checker for the sprite atlas first-fit placer: mirrors the texture
// and box tables, predicts each placement and compares it with the DUT output.
// Depends on safp_pkg for register indexes and reset defaults.
module safp_placement_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [safp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [safp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [safp_pkg::DIM_W-1:0]      sprite_width,
  input  logic [safp_pkg::DIM_W-1:0]      sprite_height,
  input  logic [safp_pkg::FMT_W-1:0]      format_code,
  input  logic                            no_merge,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [safp_pkg::TIDX_W-1:0]     texture_index,
  input  logic [safp_pkg::DIM_W-1:0]      box_x,
  input  logic [safp_pkg::DIM_W-1:0]      box_y,
  input  logic                            opened_new,
  input  logic                            overflow,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import safp_pkg::*;

  localparam int TEX_SLOTS = 16;
  localparam int BOX_SLOTS = 256;
  localparam int GRID      = 8;

  typedef struct packed {
    logic [TIDX_W-1:0] tex;
    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  y;
    logic              opened;
    logic              ovf;
  } placement_t;

  int     max_w, max_h, pad;
  bit     pow2;
  int     tex_total, box_total;
  int     tex_fmt [TEX_SLOTS];
  bit     tex_solo[TEX_SLOTS];
  int     tex_w   [TEX_SLOTS];
  int     tex_h   [TEX_SLOTS];
  longint tex_free[TEX_SLOTS];
  int     bx [BOX_SLOTS];
  int     by [BOX_SLOTS];
  int     bw_[BOX_SLOTS];
  int     bh_[BOX_SLOTS];
  int     btex[BOX_SLOTS];

  placement_t expected_placements[$];

  function automatic int pow2_ceil(int v);
    int p;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  function automatic bit spot_free(int t, int x, int y, int w, int h);
    if (x < 0 || y < 0 || x + w > tex_w[t] || y + h > tex_h[t]) return 0;
    for (int k = 0; k < box_total; k++) begin
      if (btex[k] == t && x < bx[k] + bw_[k] && bx[k] < x + w &&
          y < by[k] + bh_[k] && by[k] < y + h) return 0;
    end
    return 1;
  endfunction

  function automatic bit scan_tex(int t, int w, int h, output int ox, output int oy);
    ox = 0;
    oy = 0;
    for (int y = 0; y < tex_h[t] - h; y += GRID) begin
      for (int x = 0; x < tex_w[t] - w; x += GRID) begin
        if (spot_free(t, x, y, w, h)) begin
          for (int dy = GRID - 1; dy >= 0; dy--) begin
            for (int dx = GRID - 1; dx >= 0; dx--) begin
              if (spot_free(t, x - dx, y - dy, w, h)) begin
                ox = x - dx;
                oy = y - dy;
                return 1;
              end
            end
          end
          ox = x;
          oy = y;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic void add_box(int t, int x, int y, int w, int h);
    bx[box_total]   = x & 16'h3FFF;
    by[box_total]   = y & 16'h3FFF;
    bw_[box_total]  = w & 16'h3FFF;
    bh_[box_total]  = h & 16'h3FFF;
    btex[box_total] = t;
    box_total++;
  endfunction

  function automatic placement_t predict_placement(int sw, int sh, int fmt, bit nm);
    placement_t r;
    int     w, h, tw, th, px, py, t;
    longint barea, tarea;
    r = '0;
    if (box_total >= BOX_SLOTS) begin
      r.ovf = 1'b1;
      return r;
    end
    if (nm) begin
      w = sw;
      h = sh;
      tw = sw;
      th = sh;
    end else begin
      w = sw + 2 * pad;
      h = sh + 2 * pad;
      if (sw > max_w || sh > max_h) begin
        tw = sw;
        th = sh;
      end else begin
        for (t = 0; t < tex_total; t++) begin
          if (tex_fmt[t] != fmt || tex_solo[t]) continue;
          if (tex_free[t] < longint'(sw) * sh) continue;
          if (scan_tex(t, w, h, px, py)) begin
            barea = longint'(w) * h;
            add_box(t, px, py, w, h);
            tex_free[t] = tex_free[t] > barea ? tex_free[t] - barea : 0;
            r.tex = TIDX_W'(t);
            r.x = DIM_W'(px);
            r.y = DIM_W'(py);
            return r;
          end
        end
        tw = max_w;
        th = max_h;
      end
    end
    if (tex_total >= TEX_SLOTS) begin
      r.ovf = 1'b1;
      return r;
    end
    if (pow2) begin
      tw = pow2_ceil(tw);
      th = pow2_ceil(th);
    end
    t = tex_total;
    tex_fmt[t]  = fmt;
    tex_solo[t] = nm;
    tex_w[t]    = tw & 16'h3FFF;
    tex_h[t]    = th & 16'h3FFF;
    tarea = longint'(tw) * th;
    barea = longint'(w) * h;
    tex_free[t] = tarea > barea ? tarea - barea : 0;
    tex_total++;
    add_box(t, 0, 0, w, h);
    r.tex = TIDX_W'(t);
    r.opened = 1'b1;
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    placement_t got, want, fresh;
    if (rst) begin
      max_w = RST_MAX_W;
      max_h = RST_MAX_H;
      pad = RST_PADDING;
      pow2 = RST_POW2;
      tex_total = 0;
      box_total = 0;
      expected_placements.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_W:   max_w = cfg_data;
          CFG_MAX_H:   max_h = cfg_data;
          CFG_PADDING: pad = cfg_data[PAD_W-1:0];
          CFG_POW2:    pow2 = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fresh = predict_placement(sprite_width, sprite_height, format_code, no_merge);
        expected_placements.insert(expected_placements.size(), fresh);
      end
      if (out_valid && out_ready) begin
        got = '{texture_index, box_x, box_y, opened_new, overflow};
        if (expected_placements.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("placement with none pending: tex %0d x %0d y %0d new %0b ovf %0b",
                     got.tex, got.x, got.y, got.opened, got.ovf);
        end else begin
          want = expected_placements.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"placement mismatch: exp tex %0d x %0d y %0d new %0b ovf %0b,",
                        " got tex %0d x %0d y %0d new %0b ovf %0b"},
                       want.tex, want.x, want.y, want.opened, want.ovf,
                       got.tex, got.x, got.y, got.opened, got.ovf);
          end
        end
      end
    end
    pending <= expected_placements.size();
  end

endmodule

>>> test/sprite_atlas_first_fit_placer_core_tb.sv
// Testbench top for sprite_atlas_first_fit_placer_core: drives sprite requests
// and register writes, and reports the verdict of safp_placement_checker.
// Depends on safp_pkg, the placer RTL and test/safp_placement_checker.sv.
module sprite_atlas_first_fit_placer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import safp_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready;
  logic [DIM_W-1:0]      sprite_width, sprite_height;
  logic [FMT_W-1:0]      format_code;
  logic                  no_merge;
  logic                  out_valid, out_ready;
  logic [TIDX_W-1:0]     texture_index;
  logic [DIM_W-1:0]      box_x, box_y;
  logic                  opened_new, overflow;
  int                    mismatches, pending;

  sprite_atlas_first_fit_placer_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sprite_width(sprite_width), .sprite_height(sprite_height),
    .format_code(format_code), .no_merge(no_merge),
    .out_valid(out_valid), .out_ready(out_ready),
    .texture_index(texture_index), .box_x(box_x), .box_y(box_y),
    .opened_new(opened_new), .overflow(overflow)
  );

  safp_placement_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sprite_width(sprite_width), .sprite_height(sprite_height),
    .format_code(format_code), .no_merge(no_merge),
    .out_valid(out_valid), .out_ready(out_ready),
    .texture_index(texture_index), .box_x(box_x), .box_y(box_y),
    .opened_new(opened_new), .overflow(overflow),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 8) return $urandom_range(2, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sprite(int w, int h, int fmt, bit nm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    sprite_width  <= DIM_W'(w);
    sprite_height <= DIM_W'(h);
    format_code   <= FMT_W'(fmt);
    no_merge      <= nm;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_sprite();
    int w, h, fmt;
    bit nm;
    nm  = ($urandom_range(0, 11) == 0);
    fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(1, 4096);
      h = $urandom_range(1, 4096);
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
    end
    send_sprite(w, h, fmt, nm);
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    sprite_width  <= '0;
    sprite_height <= '0;
    format_code   <= '0;
    no_merge      <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sprite(4096, 4096, 15, 1'b1);
    send_sprite(1, 1, 15, 1'b1);
    send_sprite(4096, 1, 15, 1'b0);
    send_sprite(1, 1, 13, 1'b0);
    send_sprite(1, 1, 13, 1'b0);

    write_reg(CFG_MAX_W, 4096);
    write_reg(CFG_MAX_H, 4096);
    write_reg(CFG_PADDING, 64);
    write_reg(CFG_POW2, 0);
    send_sprite(4096, 4096, 14, 1'b0);
    send_sprite(1, 1, 13, 1'b0);

    write_reg(CFG_MAX_W, 1);
    write_reg(CFG_MAX_H, 1);
    write_reg(CFG_PADDING, 0);
    write_reg(CFG_POW2, 1);
    send_sprite(1, 1, 13, 1'b0);
    send_sprite(2, 1, 12, 1'b0);
    send_sprite(1, 1, 12, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_MAX_W, $urandom_range(16, 48));
      write_reg(CFG_MAX_H, $urandom_range(16, 48));
      write_reg(CFG_PADDING, $urandom_range(0, 3));
      write_reg(CFG_POW2, $urandom_range(0, 1));
      repeat (35) random_sprite();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sprite_atlas_first_fit_placer_core_tb: clean");
    end else begin
      $display("sprite_atlas_first_fit_placer_core_tb: errors");
    end
    $finish;
  end

  initial begin
    int hold_on, hold_off;
    forever begin
      hold_on = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (hold_on) @(posedge clk);
      hold_off = pick_gap();
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("sprite_atlas_first_fit_placer_core_tb: errors");
    $finish;
  end

endmodule
